// ===== src/rms_pkg.sv =====
// Shared types and constants for the rate-monotonic task scheduler.
`timescale 1ns / 1ps

package rms_pkg;

  // Default build of the scheduler
  localparam int NUM_TASKS_DEF  = 4;
  localparam int TIME_WIDTH_DEF = 16;

  // Configuration port
  localparam int CFG_WIDTH = 16;
  localparam int CFG_IDX_W = 3;

  // Register map: periods first, then run times
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WCET_0   = 3'd4;

  // Width of a task index on the result port
  localparam int TASK_IDX_W = 2;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] running_task;
    logic                  idle;
    logic                  deadline_missed;
    logic [TASK_IDX_W-1:0] missed_task;
    logic                  halted;
  } result_t;

endpackage

// ===== src/rate_monotonic_task_scheduler_unit.sv =====
// Top level of the rate-monotonic task scheduler: config port, request channel, result register.
//
// Preemptive rate-monotonic scheduler for up to four periodic tasks.
// Input channel (in_valid_i / in_ready_o, payload restart_i): one request per
// time slot. restart_i = 1 releases every task with a nonzero run time and
// starts time at zero; restart_i = 0 is one slot tick.
// Output channel (out_valid_o / out_ready_i): one result per request with the
// task run in the slot, idle, deadline miss, missed task and halted flags.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at the
// clock edge (0..3 periods, 4..7 run times); write only while idle.
// The result is registered: it is valid the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the priority pick,
// countdown and release logic for all tasks is combinational from the state registers.
// When the receiver stalls, the result register holds and in_ready_o stays
// high only if the held result is taken in the same cycle.
// Reset clears all task state and the halt flag, sets periods to one and run
// times to zero, and empties the result register.
`timescale 1ns / 1ps

module rate_monotonic_task_scheduler_unit #(
  parameter int NUM_TASKS  = rms_pkg::NUM_TASKS_DEF,
  parameter int TIME_WIDTH = rms_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rms_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rms_pkg::CFG_WIDTH-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rms_pkg::TASK_IDX_W-1:0]      running_task_o,
  output logic                                idle_o,
  output logic                                deadline_missed_o,
  output logic [rms_pkg::TASK_IDX_W-1:0]      missed_task_o,
  output logic                                halted_o
);

  logic [TIME_WIDTH-1:0] period   [NUM_TASKS];
  logic [TIME_WIDTH-1:0] wcet     [NUM_TASKS];
  logic                  enabled  [NUM_TASKS];
  logic                  accept;
  rms_pkg::result_t      res;
  rms_pkg::result_t      res_q;
  logic                  out_valid_q;

  rms_cfg #(
    .NUM_TASKS  (NUM_TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .period_o   (period),
    .wcet_o     (wcet),
    .enabled_o  (enabled)
  );

  rms_sched #(
    .NUM_TASKS  (NUM_TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .restart_i (restart_i),
    .period_i  (period),
    .wcet_i    (wcet),
    .enabled_i (enabled),
    .res_o     (res)
  );

  // take a new request whenever the result register is free or drains now
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign running_task_o    = res_q.running_task;
  assign idle_o            = res_q.idle;
  assign deadline_missed_o = res_q.deadline_missed;
  assign missed_task_o     = res_q.missed_task;
  assign halted_o          = res_q.halted;

endmodule

// ===== src/rms_cfg.sv =====
// Configuration registers: task periods and run times, saturated to the time width.
`timescale 1ns / 1ps

module rms_cfg #(
  parameter int NUM_TASKS  = rms_pkg::NUM_TASKS_DEF,
  parameter int TIME_WIDTH = rms_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rms_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  output logic [TIME_WIDTH-1:0]          period_o [NUM_TASKS],
  output logic [TIME_WIDTH-1:0]          wcet_o   [NUM_TASKS],
  output logic                           enabled_o [NUM_TASKS]
);

  localparam int CW = rms_pkg::CFG_WIDTH;

  logic [CW-1:0] period_q [NUM_TASKS];
  logic [CW-1:0] wcet_q   [NUM_TASKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        period_q[i] <= CW'(1);
        wcet_q[i]   <= '0;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (cfg_idx_i[1:0] == 2'(i)) begin
          if (cfg_idx_i < rms_pkg::REG_WCET_0) begin
            period_q[i] <= cfg_data_i;
          end else begin
            wcet_q[i] <= cfg_data_i;
          end
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_task
    logic [TIME_WIDTH-1:0] period_sat;
    logic [TIME_WIDTH-1:0] wcet_sat;

    if (TIME_WIDTH >= CW) begin : g_wide
      assign period_sat = TIME_WIDTH'(period_q[g]);
      assign wcet_sat   = TIME_WIDTH'(wcet_q[g]);
    end else begin : g_narrow
      // clamp at the largest count the time width can hold
      assign period_sat = (|period_q[g][CW-1:TIME_WIDTH]) ? '1 :
                          period_q[g][TIME_WIDTH-1:0];
      assign wcet_sat   = (|wcet_q[g][CW-1:TIME_WIDTH]) ? '1 :
                          wcet_q[g][TIME_WIDTH-1:0];
    end

    // a period of zero runs as a period of one
    assign period_o[g]  = (period_sat == '0) ? TIME_WIDTH'(1) : period_sat;
    assign wcet_o[g]    = wcet_sat;
    assign enabled_o[g] = (wcet_q[g] != '0);
  end

endmodule

// ===== src/rms_sched.sv =====
// Scheduler state and per-slot decision: priority pick, countdowns, releases, miss check.
`timescale 1ns / 1ps

module rms_sched #(
  parameter int NUM_TASKS  = rms_pkg::NUM_TASKS_DEF,
  parameter int TIME_WIDTH = rms_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  restart_i,
  input  logic [TIME_WIDTH-1:0] period_i  [NUM_TASKS],
  input  logic [TIME_WIDTH-1:0] wcet_i    [NUM_TASKS],
  input  logic                  enabled_i [NUM_TASKS],
  output rms_pkg::result_t      res_o
);

  localparam int IW = rms_pkg::TASK_IDX_W;

  logic [TIME_WIDTH-1:0] rem_q [NUM_TASKS];
  logic [TIME_WIDTH-1:0] rem_d [NUM_TASKS];
  logic [TIME_WIDTH-1:0] cnt_q [NUM_TASKS];
  logic [TIME_WIDTH-1:0] cnt_d [NUM_TASKS];
  logic                  stopped_q;
  logic                  stopped_d;

  logic                  run_found;
  logic [IW-1:0]         run_idx;
  logic [TIME_WIDTH-1:0] run_period;
  logic                  miss_found;
  logic [IW-1:0]         miss_idx;

  // shortest period among ready tasks, lowest index wins a tie
  always_comb begin
    run_found  = 1'b0;
    run_idx    = '0;
    run_period = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (rem_q[i] != '0 && (!run_found || period_i[i] < run_period)) begin
        run_found  = 1'b1;
        run_idx    = IW'(i);
        run_period = period_i[i];
      end
    end
  end

  always_comb begin
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    stopped_d  = stopped_q;
    miss_found = 1'b0;
    miss_idx   = '0;
    res_o      = '{running_task: '0, idle: 1'b1, deadline_missed: 1'b0,
                   missed_task: '0, halted: 1'b0};

    if (restart_i) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        rem_d[i] = wcet_i[i];
        cnt_d[i] = period_i[i];
      end
      stopped_d = 1'b0;
    end else if (stopped_q) begin
      res_o.halted = 1'b1;
    end else begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (run_found && run_idx == IW'(i)) begin
          rem_d[i] = rem_q[i] - TIME_WIDTH'(1);
        end
      end
      if (run_found) begin
        res_o.running_task = run_idx;
        res_o.idle         = 1'b0;
      end

      // end of slot: advance countdowns, release at period boundaries
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (cnt_q[i] <= TIME_WIDTH'(1)) begin
          cnt_d[i] = period_i[i];
          if (enabled_i[i]) begin
            if (rem_d[i] != '0) begin
              if (!miss_found) begin
                miss_found = 1'b1;
                miss_idx   = IW'(i);
              end
            end else begin
              rem_d[i] = wcet_i[i];
            end
          end
        end else begin
          cnt_d[i] = cnt_q[i] - TIME_WIDTH'(1);
        end
      end

      if (miss_found) begin
        stopped_d             = 1'b1;
        res_o.deadline_missed = 1'b1;
        res_o.missed_task     = miss_idx;
        res_o.halted          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        rem_q[i] <= '0;
        cnt_q[i] <= '0;
      end
      stopped_q <= 1'b0;
    end else if (step_i) begin
      rem_q     <= rem_d;
      cnt_q     <= cnt_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

// ===== tb/tb_rate_monotonic_task_scheduler_unit.sv =====
// Self-checking testbench for the rate-monotonic task scheduler unit.
`timescale 1ns / 1ps

module tb_rate_monotonic_task_scheduler_unit;

  localparam int TASKS = 4;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [rms_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [rms_pkg::CFG_WIDTH-1:0]  cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic                           restart_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [rms_pkg::TASK_IDX_W-1:0] running_task_o;
  logic                           idle_o;
  logic                           deadline_missed_o;
  logic [rms_pkg::TASK_IDX_W-1:0] missed_task_o;
  logic                           halted_o;

  rate_monotonic_task_scheduler_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .restart_i         (restart_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .running_task_o    (running_task_o),
    .idle_o            (idle_o),
    .deadline_missed_o (deadline_missed_o),
    .missed_task_o     (missed_task_o),
    .halted_o          (halted_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scheduler state mirrored by the testbench
  logic [TASKS-1:0][15:0] cfg_period = {16'd1, 16'd1, 16'd1, 16'd1};
  logic [TASKS-1:0][15:0] cfg_wcet   = '0;
  logic [TASKS-1:0][15:0] slots_left = '0;
  logic [TASKS-1:0][15:0] next_release = '0;
  bit                     sched_halted = 1'b0;

  rms_pkg::result_t slot_results_q[$];
  int               error_count = 0;
  bit               stalls_on = 1'b1;

  function automatic logic [15:0] eff_period(input int t);
    return (cfg_period[t] == 16'd0) ? 16'd1 : cfg_period[t];
  endfunction

  // One time slot of the scheduler: pick, run, then count down to releases
  function automatic rms_pkg::result_t schedule_slot(input logic restart);
    rms_pkg::result_t r;
    int               pick;
    int               miss;
    r      = '0;
    r.idle = 1'b1;
    pick   = -1;
    miss   = -1;
    if (restart) begin
      for (int t = 0; t < TASKS; t++) begin
        slots_left[t]   = cfg_wcet[t];
        next_release[t] = eff_period(t);
      end
      sched_halted = 1'b0;
      return r;
    end
    if (sched_halted) begin
      r.halted = 1'b1;
      return r;
    end
    for (int t = 0; t < TASKS; t++) begin
      if (slots_left[t] != 16'd0 && (pick < 0 || eff_period(t) < eff_period(pick)))
        pick = t;
    end
    if (pick >= 0) begin
      slots_left[pick] = slots_left[pick] - 16'd1;
      r.running_task   = rms_pkg::TASK_IDX_W'(pick);
      r.idle           = 1'b0;
    end
    for (int t = 0; t < TASKS; t++) begin
      if (next_release[t] <= 16'd1) begin
        next_release[t] = eff_period(t);
        // disabled tasks reload but are neither released nor checked
        if (cfg_wcet[t] != 16'd0) begin
          if (slots_left[t] != 16'd0) begin
            if (miss < 0) miss = t;
          end else begin
            slots_left[t] = cfg_wcet[t];
          end
        end
      end else begin
        next_release[t] = next_release[t] - 16'd1;
      end
    end
    if (miss >= 0) begin
      sched_halted      = 1'b1;
      r.deadline_missed = 1'b1;
      r.missed_task     = rms_pkg::TASK_IDX_W'(miss);
      r.halted          = 1'b1;
    end
    return r;
  endfunction

  // Hold valid across back-to-back requests; drop it only for a gap
  task automatic send_request(input logic restart);
    while (stalls_on && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    slot_results_q = {slot_results_q, schedule_slot(restart)};
  endtask

  task automatic send_ticks(input int count);
    for (int n = 0; n < count; n++) send_request(1'b0);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (slot_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [TASKS-1:0][15:0] periods,
                              input logic [TASKS-1:0][15:0] wcets);
    wait_idle();
    for (int r = 0; r < 2 * TASKS; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= (r < TASKS) ? rms_pkg::CFG_IDX_W'(rms_pkg::REG_PERIOD_0 + r)
                                : rms_pkg::CFG_IDX_W'(rms_pkg::REG_WCET_0 + (r - TASKS));
      cfg_data_i <= (r < TASKS) ? periods[r] : wcets[r - TASKS];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    cfg_period  = periods;
    cfg_wcet    = wcets;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rms_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (slot_results_q.size() == 0) begin
        $display("%0t: result with no request outstanding, actual task %0d idle %0b",
                 $time, running_task_o, idle_o);
        error_count++;
      end else begin
        want = slot_results_q.pop_front();
        compare_field("running_task", want.running_task, running_task_o);
        compare_field("idle", want.idle, idle_o);
        compare_field("deadline_missed", want.deadline_missed, deadline_missed_o);
        compare_field("missed_task", want.missed_task, missed_task_o);
        compare_field("halted", want.halted, halted_o);
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !stalls_on || ($urandom_range(99) >= 35);
  end

  // Ticks at reset values, then ticks after a config with no restart at all
  task automatic test_before_restart();
    send_ticks(2);
    apply_config({16'd4, 16'd1, 16'd3, 16'd2}, {16'd0, 16'd1, 16'd1, 16'd1});
    send_ticks(4);
  endtask

  // Shortest period wins, equal periods go to the lower index
  task automatic test_priority_and_ties();
    apply_config({16'd0, 16'd3, 16'd3, 16'd4}, {16'd0, 16'd1, 16'd1, 16'd1});
    send_request(1'b1);
    send_ticks(4);
  endtask

  // Several tasks miss at once; halted ticks change nothing until restart
  task automatic test_deadline_miss();
    apply_config({16'd2, 16'd2, 16'd2, 16'd2}, {16'd2, 16'd2, 16'd2, 16'd2});
    send_request(1'b1);
    send_ticks(3);
    send_request(1'b1);
  endtask

  // Disable a task while its job is in flight: the job runs out, no new release
  task automatic test_disabled_job_finishes();
    apply_config({16'd5, 16'd5, 16'd5, 16'd2}, {16'd0, 16'd0, 16'd0, 16'd2});
    send_request(1'b1);
    apply_config({16'd5, 16'd5, 16'd5, 16'd2}, '0);
    send_ticks(3);
  endtask

  task automatic test_extremes();
    apply_config({16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF}, {16'd1, 16'd0, 16'd0, 16'hFFFF});
    send_request(1'b1);
    send_ticks(3);
    apply_config({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1}, {16'd0, 16'd0, 16'd0, 16'hFFFF});
    send_request(1'b1);
    send_ticks(2);
  endtask

  task automatic test_random_schedules();
    logic [TASKS-1:0][15:0] periods;
    logic [TASKS-1:0][15:0] wcets;
    int                     mode;
    for (int phase = 0; phase < 30; phase++) begin
      stalls_on = !(phase >= 12 && phase < 17);
      mode      = $urandom_range(9);
      for (int t = 0; t < TASKS; t++) begin
        if (mode == 0) begin
          case ($urandom_range(3))
            0: periods[t] = 16'd0;
            1: periods[t] = 16'd1;
            2: periods[t] = 16'hFFFF;
            default: periods[t] = 16'($urandom_range(65535));
          endcase
          case ($urandom_range(2))
            0: wcets[t] = 16'd0;
            1: wcets[t] = 16'hFFFF;
            default: wcets[t] = 16'($urandom_range(65535));
          endcase
        end else begin
          periods[t] = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
          wcets[t]   = 16'($urandom_range(0, 2));
        end
      end
      apply_config(periods, wcets);
      if ($urandom_range(4) != 0) send_request(1'b1);
      for (int n = 0; n < 60; n++) begin
        // restart about half of the halted schedules so runs reach later hyperperiods
        if (sched_halted) send_request($urandom_range(1) == 1);
        else send_request($urandom_range(49) == 0);
      end
    end
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_restart();
    test_priority_and_ties();
    test_deadline_miss();
    test_disabled_job_finishes();
    test_extremes();
    test_random_schedules();
    in_valid_i <= 1'b0;
    for (int n = 0; n < 2000 && slot_results_q.size() != 0; n++) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (slot_results_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, slot_results_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_rate_monotonic_task_scheduler_unit: PASS");
    end else begin
      $display("tb_rate_monotonic_task_scheduler_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_rate_monotonic_task_scheduler_unit: FAIL");
    $finish;
  end

endmodule

// ===== rate_monotonic_task_scheduler_unit.f =====
src/rms_pkg.sv
src/rms_cfg.sv
src/rms_sched.sv
src/rate_monotonic_task_scheduler_unit.sv
tb/tb_rate_monotonic_task_scheduler_unit.sv
